// ----- hdl/multitap_keypad_text_entry_macros.svh -----
// assertion macros shared by the checker of the keypad text entry block
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_MACROS_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_MACROS_SVH

// same-cycle implication, checked out of reset
`define MTKTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MTKTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mtkte_pkg.sv -----
// types, constants and glyph tables of the multi-tap keypad text entry block
// no dependencies
package mtkte_pkg;

  // field widths
  localparam int unsigned KeyW     = 2;
  localparam int unsigned RowW     = 2;
  localparam int unsigned CharW    = 7;
  localparam int unsigned PosW     = 4;
  localparam int unsigned LenW     = 5;
  localparam int unsigned TickW    = 8;
  localparam int unsigned TapW     = 4;
  localparam int unsigned NumRows  = 4;
  localparam int unsigned NumKeys  = 3;
  localparam int unsigned MaxTaps  = 9;

  // buffer depth default
  localparam int unsigned TextDepthDef = 16;

  // configuration port
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;
  localparam logic        RegIdxTimeout = 1'b0;
  localparam logic [TickW-1:0] TimeoutRst = 8'd100;

  // key that leaves a row
  localparam logic [KeyW-1:0] ReturnKey = 2'd3;

  typedef enum logic {
    MODE_KEY  = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e           mode;
    logic [KeyW-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic             in_row;
    logic [RowW-1:0]  row;
    logic             pending_valid;
    logic [CharW-1:0] pending_char;
    logic             commit_valid;
    logic [CharW-1:0] commit_char;
    logic [PosW-1:0]  commit_pos;
    logic [LenW-1:0]  text_length;
    logic             buffer_full;
  } out_item_t;

  // request from the tap logic to the text buffer
  typedef struct packed {
    logic             req;
    logic [CharW-1:0] ch;
  } commit_req_t;

  // what the text buffer did with the request
  typedef struct packed {
    logic            written;
    logic            dropped;
    logic [PosW-1:0] pos;
    logic [LenW-1:0] length;
  } commit_rsp_t;

  // characters per letter key
  localparam logic [TapW-1:0] GLYPH_CNT [NumRows][NumKeys] = '{
    '{4'd6, 4'd7, 4'd7},
    '{4'd7, 4'd7, 4'd7},
    '{4'd9, 4'd7, 4'd9},
    '{4'd1, 4'd1, 4'd1}
  };

  // ascii codes per row and key, unused slots zero
  localparam logic [CharW-1:0] GLYPH_TBL [NumRows][NumKeys][MaxTaps] = '{
    '{ '{7'h2E, 7'h2C, 7'h2D, 7'h3F, 7'h21, 7'h31, 7'h00, 7'h00, 7'h00},
       '{7'h61, 7'h62, 7'h63, 7'h41, 7'h42, 7'h43, 7'h32, 7'h00, 7'h00},
       '{7'h64, 7'h65, 7'h66, 7'h44, 7'h45, 7'h46, 7'h33, 7'h00, 7'h00} },
    '{ '{7'h67, 7'h68, 7'h69, 7'h47, 7'h48, 7'h49, 7'h34, 7'h00, 7'h00},
       '{7'h6A, 7'h6B, 7'h6C, 7'h4A, 7'h4B, 7'h4C, 7'h35, 7'h00, 7'h00},
       '{7'h6D, 7'h6E, 7'h6F, 7'h4D, 7'h4E, 7'h4F, 7'h36, 7'h00, 7'h00} },
    '{ '{7'h70, 7'h71, 7'h72, 7'h73, 7'h50, 7'h51, 7'h52, 7'h53, 7'h37},
       '{7'h74, 7'h75, 7'h76, 7'h54, 7'h55, 7'h56, 7'h38, 7'h00, 7'h00},
       '{7'h77, 7'h78, 7'h79, 7'h7A, 7'h57, 7'h58, 7'h59, 7'h5A, 7'h39} },
    '{ '{7'h2A, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
       '{7'h30, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
       '{7'h23, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00} }
  };

  // return key maps onto the first letter key
  function automatic logic [KeyW-1:0] letter_key(logic [KeyW-1:0] key);
    return (key == ReturnKey) ? '0 : key;
  endfunction

  function automatic logic [TapW-1:0] glyph_count(logic [RowW-1:0] row,
                                                  logic [KeyW-1:0] key);
    logic [KeyW-1:0] k;
    k = letter_key(key);
    return GLYPH_CNT[row][k];
  endfunction

  // character for a row, key and tap count; out-of-range taps give the first
  function automatic logic [CharW-1:0] glyph_char(logic [RowW-1:0] row,
                                                  logic [KeyW-1:0] key,
                                                  logic [TapW-1:0] tap);
    logic [KeyW-1:0] k;
    logic [TapW-1:0] t;
    k = letter_key(key);
    t = (tap >= GLYPH_CNT[row][k]) ? '0 : tap;
    return GLYPH_TBL[row][k][t];
  endfunction

endpackage

// ----- hdl/mtkte_stream_if.sv -----
// valid/ready channel carrying one item per handshake
// payload type comes from mtkte_pkg at the instance
interface mtkte_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/mtkte_text_buf.sv -----
// text buffer: fill count, store and the full decision for commits
// depends on mtkte_pkg
module mtkte_text_buf #(
  parameter int unsigned TEXT_DEPTH = mtkte_pkg::TextDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  mtkte_pkg::commit_req_t req_i,
  output mtkte_pkg::commit_rsp_t rsp_o
);

  localparam int unsigned CntW  = $clog2(TEXT_DEPTH + 1);
  localparam int unsigned AddrW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int unsigned ExtW  = CntW + mtkte_pkg::LenW;

  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [mtkte_pkg::CharW-1:0] store_q [TEXT_DEPTH];
  logic                        has_room;
  logic [ExtW-1:0]             cnt_cur_ext, cnt_nxt_ext;

  // room check and next fill count
  always_comb begin
    has_room      = cnt_q < CntW'(TEXT_DEPTH);
    rsp_o.written = req_i.req && has_room;
    rsp_o.dropped = req_i.req && !has_room;
    cnt_d         = rsp_o.written ? cnt_q + CntW'(1) : cnt_q;
    cnt_cur_ext   = ExtW'(cnt_q);
    cnt_nxt_ext   = ExtW'(cnt_d);
    rsp_o.pos     = cnt_cur_ext[mtkte_pkg::PosW-1:0];
    rsp_o.length  = cnt_nxt_ext[mtkte_pkg::LenW-1:0];
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  // character store, written at the fill position
  always_ff @(posedge clk_i) begin
    if (step_i && rsp_o.written) begin
      store_q[cnt_q[AddrW-1:0]] <= req_i.ch;
    end
  end

endmodule

// ----- hdl/multitap_keypad_text_entry.sv -----
// top level of the multi-tap keypad text entry block
// depends on mtkte_pkg, mtkte_stream_if and mtkte_text_buf
//
//  channel     dir  handshake            payload
//  in_chan_i   in   valid/ready          mode, key
//  out_chan_o  out  valid/ready          in_row .. buffer_full (one item per input)
//  apb         in   psel/penable/pready  commit_timeout_ticks at address 0
//
// the table lookup and counter update sit between the state registers and a
// two-entry output queue, so an item is taken each cycle while the queue has room
// in_chan_i.ready drops only when both output entries are full
// rst_ni clears the tap state, fill count and queue valid flags; the timeout register resets to 100
// the text store itself has no reset and is never read
module multitap_keypad_text_entry #(
  parameter int unsigned TEXT_DEPTH = mtkte_pkg::TextDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mtkte_stream_if.sink                     in_chan_i,
  mtkte_stream_if.source                   out_chan_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mtkte_pkg::ApbAddrW-1:0]   paddr,
  input  logic [mtkte_pkg::ApbDataW-1:0]   pwdata,
  output logic [mtkte_pkg::ApbDataW-1:0]   prdata,
  output logic                             pready
);

  // configuration register
  logic [mtkte_pkg::TickW-1:0] timeout_q;
  logic                        cfg_we;

  // tap state
  logic                        row_sel_q, row_sel_d;
  logic [mtkte_pkg::RowW-1:0]  row_q, row_d;
  logic                        pend_q, pend_d;
  logic [mtkte_pkg::KeyW-1:0]  pend_key_q, pend_key_d;
  logic [mtkte_pkg::TapW-1:0]  tap_q, tap_d, tap_inc;
  logic [mtkte_pkg::TickW-1:0] idle_q, idle_d, idle_inc;

  // item handshake and result
  mtkte_pkg::in_item_t    item;
  mtkte_pkg::out_item_t   res;
  mtkte_pkg::commit_req_t commit_req;
  mtkte_pkg::commit_rsp_t commit_rsp;
  logic                   in_acc;

  // output queue: head and skid entry
  mtkte_pkg::out_item_t head_q, skid_q;
  logic                 head_vld_q, skid_vld_q;
  logic                 head_pop;

  // apb register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == mtkte_pkg::RegIdxTimeout);
  assign prdata = (paddr[2] == mtkte_pkg::RegIdxTimeout)
                ? mtkte_pkg::ApbDataW'(timeout_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= mtkte_pkg::TimeoutRst;
    end else if (cfg_we) begin
      timeout_q <= pwdata[mtkte_pkg::TickW-1:0];
    end
  end

  assign item   = in_chan_i.payload;
  assign in_acc = in_chan_i.valid && in_chan_i.ready;

  // next tap state for the incoming item
  always_comb begin
    row_sel_d  = row_sel_q;
    row_d      = row_q;
    pend_d     = pend_q;
    pend_key_d = pend_key_q;
    tap_d      = tap_q;
    idle_d     = idle_q;
    commit_req = '0;
    tap_inc    = tap_q + mtkte_pkg::TapW'(1);
    idle_inc   = (idle_q != '1) ? idle_q + mtkte_pkg::TickW'(1) : idle_q;
    case (item.mode)
      mtkte_pkg::MODE_KEY: begin
        if (!row_sel_q) begin
          row_sel_d = 1'b1;
          row_d     = item.key;
        end else if (pend_q) begin
          // repeat press steps through the key's characters
          if (item.key == pend_key_q) begin
            tap_d  = (tap_inc >= mtkte_pkg::glyph_count(row_q, pend_key_q)) ? '0 : tap_inc;
            idle_d = '0;
          end
        end else if (item.key == mtkte_pkg::ReturnKey) begin
          row_sel_d = 1'b0;
          row_d     = '0;
        end else begin
          pend_d     = 1'b1;
          pend_key_d = item.key;
          tap_d      = '0;
          idle_d     = '0;
        end
      end
      mtkte_pkg::MODE_TICK: begin
        if (pend_q) begin
          idle_d = idle_inc;
          if (idle_inc >= timeout_q) begin
            commit_req.req = 1'b1;
            commit_req.ch  = mtkte_pkg::glyph_char(row_q, pend_key_q, tap_q);
            pend_d         = 1'b0;
            pend_key_d     = '0;
            tap_d          = '0;
            idle_d         = '0;
          end
        end
      end
      default: begin
        commit_req = '0;
      end
    endcase
  end

  mtkte_text_buf #(
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_text_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_acc),
    .req_i  (commit_req),
    .rsp_o  (commit_rsp)
  );

  // result item after the update
  always_comb begin
    res.in_row        = row_sel_d;
    res.row           = row_sel_d ? row_d : '0;
    res.pending_valid = pend_d;
    res.pending_char  = pend_d ? mtkte_pkg::glyph_char(row_d, pend_key_d, tap_d) : '0;
    res.commit_valid  = commit_rsp.written;
    res.commit_char   = commit_rsp.written ? commit_req.ch : '0;
    res.commit_pos    = commit_rsp.written ? commit_rsp.pos : '0;
    res.text_length   = commit_rsp.length;
    res.buffer_full   = commit_rsp.dropped;
  end

  // tap state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sel_q  <= 1'b0;
      row_q      <= '0;
      pend_q     <= 1'b0;
      pend_key_q <= '0;
      tap_q      <= '0;
      idle_q     <= '0;
    end else if (in_acc) begin
      row_sel_q  <= row_sel_d;
      row_q      <= row_d;
      pend_q     <= pend_d;
      pend_key_q <= pend_key_d;
      tap_q      <= tap_d;
      idle_q     <= idle_d;
    end
  end

  // output queue control
  assign in_chan_i.ready    = !skid_vld_q;
  assign head_pop           = head_vld_q && out_chan_o.ready;
  assign out_chan_o.valid   = head_vld_q;
  assign out_chan_o.payload = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!head_vld_q || head_pop) begin
      head_vld_q <= skid_vld_q || in_acc;
      skid_vld_q <= 1'b0;
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  // output queue data
  always_ff @(posedge clk_i) begin
    if (!head_vld_q || head_pop) begin
      head_q <= skid_vld_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

endmodule

// ----- hdl/mtkte_checker.sv -----
// port-level checks of the keypad text entry block, bound to its top level
// depends on mtkte_pkg and the assertion macros header
`include "multitap_keypad_text_entry_macros.svh"

module mtkte_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input mtkte_pkg::out_item_t out_item_i
);

  // a stalled result item holds its value
  `MTKTE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i), "result item changed while stalled")

  // a commit and a dropped commit never show together
  `MTKTE_ASSERT_NOW(a_commit_excl, out_valid_i, !(out_item_i.commit_valid && out_item_i.buffer_full), "commit and full flag together")

  // a pending character needs a selected row
  `MTKTE_ASSERT_NOW(a_pend_row, out_valid_i && out_item_i.pending_valid, out_item_i.in_row, "pending character outside a row")

  // a written character leaves the buffer non-empty
  `MTKTE_ASSERT_NOW(a_commit_len, out_valid_i && out_item_i.commit_valid, out_item_i.text_length != '0, "commit with empty buffer")

endmodule

bind multitap_keypad_text_entry mtkte_checker u_mtkte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_chan_o.valid),
  .out_ready_i (out_chan_o.ready),
  .out_item_i  (out_chan_o.payload)
);

// ----- test/tb_top.sv -----
// self-checking testbench of the multi-tap keypad text entry block
// depends on mtkte_pkg, mtkte_stream_if and multitap_keypad_text_entry
// directed and random key and tick items against a tap-entry predictor, timeout set over apb
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TextDepth   = 16;
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned MaxPrinted  = 60;
  localparam logic [mtkte_pkg::ApbAddrW-1:0] TimeoutAddr =
    mtkte_pkg::ApbAddrW'(4 * mtkte_pkg::RegIdxTimeout);

  // what the predictor keeps between items
  typedef struct packed {
    bit                         sel;
    bit [mtkte_pkg::RowW-1:0]   row;
    bit                         pend;
    bit [mtkte_pkg::KeyW-1:0]   pkey;
    bit [mtkte_pkg::TapW-1:0]   tap;
    bit [mtkte_pkg::TickW-1:0]  idle;
    bit [5:0]                   fill;
  } entry_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [mtkte_pkg::ApbAddrW-1:0] paddr   = '0;
  logic [mtkte_pkg::ApbDataW-1:0] pwdata  = '0;
  logic [mtkte_pkg::ApbDataW-1:0] prdata;
  logic                           pready;

  mtkte_stream_if #(.payload_t(mtkte_pkg::in_item_t))  in_if ();
  mtkte_stream_if #(.payload_t(mtkte_pkg::out_item_t)) out_if ();

  multitap_keypad_text_entry #(
    .TEXT_DEPTH(TextDepth)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan_i (in_if),
    .out_chan_o(out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  mtkte_pkg::in_item_t     key_event_q[$];
  mtkte_pkg::out_item_t    expected_display_q[$];
  entry_state_t entry_st = '0;
  entry_state_t plan_st  = '0;
  logic [mtkte_pkg::TickW-1:0] commit_limit = mtkte_pkg::TimeoutRst;
  int unsigned  n_queued   = 0;
  int unsigned  n_accepted = 0;
  int unsigned  n_checked  = 0;
  int unsigned  err_cnt    = 0;
  int unsigned  cycle_cnt  = 0;
  int unsigned  in_gap     = 0;
  int unsigned  out_stall  = 0;
  bit           in_calm    = 1'b0;
  bit           out_calm   = 1'b0;

  always #5 clk_i = ~clk_i;

  // characters behind one letter key of one row
  function automatic string key_glyphs(bit [mtkte_pkg::RowW-1:0] row,
                                       bit [mtkte_pkg::KeyW-1:0] key);
    case ({row, key})
      4'h0: return ".,-?!1";
      4'h1: return "abcABC2";
      4'h2: return "defDEF3";
      4'h4: return "ghiGHI4";
      4'h5: return "jklJKL5";
      4'h6: return "mnoMNO6";
      4'h8: return "pqrsPQRS7";
      4'h9: return "tuvTUV8";
      4'hA: return "wxyzWXYZ9";
      4'hC: return "*";
      4'hD: return "0";
      4'hE: return "#";
      default: return "";
    endcase
  endfunction

  // pending character, the return key reads as the first letter key
  function automatic bit [mtkte_pkg::CharW-1:0] pending_glyph(entry_state_t st);
    string       s;
    int unsigned t;
    byte         c;
    s = key_glyphs(st.row, (st.pkey == mtkte_pkg::ReturnKey) ? 2'd0 : st.pkey);
    t = 32'(st.tap);
    if (t >= s.len()) t = 0;
    c = s[t];
    return c[mtkte_pkg::CharW-1:0];
  endfunction

  // one key press or tick: update the entry state, return the display item
  function automatic mtkte_pkg::out_item_t entry_step(inout entry_state_t st,
                                                      input mtkte_pkg::in_item_t it,
                                                      input bit [mtkte_pkg::TickW-1:0] limit);
    mtkte_pkg::out_item_t        r;
    int unsigned                 n;
    bit [mtkte_pkg::CharW-1:0]   ch;
    r = '0;
    if (it.mode == mtkte_pkg::MODE_KEY) begin
      if (!st.sel) begin
        st.sel = 1'b1;
        st.row = it.key;
      end else if (st.pend) begin
        // only the same key steps the choice, any other key is ignored
        if (it.key == st.pkey) begin
          n = key_glyphs(st.row, st.pkey).len();
          st.tap = st.tap + 1'b1;
          if (st.tap >= n) st.tap = '0;
          st.idle = '0;
        end
      end else if (it.key == mtkte_pkg::ReturnKey) begin
        st.sel = 1'b0;
        st.row = '0;
      end else begin
        st.pend = 1'b1;
        st.pkey = it.key;
        st.tap  = '0;
        st.idle = '0;
      end
    end else if (st.pend) begin
      // idle count saturates, compared after the increment
      if (st.idle != '1) st.idle = st.idle + 1'b1;
      if (st.idle >= limit) begin
        ch = pending_glyph(st);
        if (st.fill < TextDepth) begin
          r.commit_valid = 1'b1;
          r.commit_char  = ch;
          r.commit_pos   = st.fill[mtkte_pkg::PosW-1:0];
          st.fill        = st.fill + 1'b1;
        end else begin
          r.buffer_full = 1'b1;
        end
        st.pend = 1'b0;
        st.pkey = '0;
        st.tap  = '0;
        st.idle = '0;
      end
    end
    r.in_row        = st.sel;
    r.row           = st.sel ? st.row : '0;
    r.pending_valid = st.pend;
    r.pending_char  = st.pend ? pending_glyph(st) : '0;
    r.text_length   = st.fill[mtkte_pkg::LenW-1:0];
    return r;
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    err_cnt++;
    if (err_cnt <= MaxPrinted)
      $display("mismatch at result %0d: %s got %0h want %0h", n_checked, what, got, want);
  endtask

  task automatic compare_display(mtkte_pkg::out_item_t got, mtkte_pkg::out_item_t want);
    if (got.in_row !== want.in_row)
      report_mismatch("in_row", 32'(got.in_row), 32'(want.in_row));
    if (got.row !== want.row) report_mismatch("row", 32'(got.row), 32'(want.row));
    if (got.pending_valid !== want.pending_valid)
      report_mismatch("pending_valid", 32'(got.pending_valid), 32'(want.pending_valid));
    if (got.pending_char !== want.pending_char)
      report_mismatch("pending_char", 32'(got.pending_char), 32'(want.pending_char));
    if (got.commit_valid !== want.commit_valid)
      report_mismatch("commit_valid", 32'(got.commit_valid), 32'(want.commit_valid));
    if (got.commit_char !== want.commit_char)
      report_mismatch("commit_char", 32'(got.commit_char), 32'(want.commit_char));
    if (got.commit_pos !== want.commit_pos)
      report_mismatch("commit_pos", 32'(got.commit_pos), 32'(want.commit_pos));
    if (got.text_length !== want.text_length)
      report_mismatch("text_length", 32'(got.text_length), 32'(want.text_length));
    if (got.buffer_full !== want.buffer_full)
      report_mismatch("buffer_full", 32'(got.buffer_full), 32'(want.buffer_full));
  endtask

  // input driver: one item from the queue, a drawn gap after each
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_gap      <= 0;
    end else begin
      if ($urandom_range(0, 39) == 0) in_calm <= !in_calm;
      if (!in_if.valid || in_if.ready) begin
        if (in_gap != 0) begin
          in_gap      <= in_gap - 1;
          in_if.valid <= 1'b0;
        end else if (key_event_q.size() != 0) begin
          in_if.payload <= key_event_q.pop_front();
          in_if.valid   <= 1'b1;
          in_gap        <= draw_wait(in_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output ready: low for a drawn stall after each item
  always @(posedge clk_i or negedge rst_ni) begin : out_pace
    int unsigned w;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if ($urandom_range(0, 39) == 0) out_calm <= !out_calm;
      if (out_if.valid && out_if.ready) begin
        w = draw_wait(out_calm);
        out_if.ready <= (w == 0);
        out_stall    <= (w == 0) ? 0 : w - 1;
      end else if (out_stall != 0) begin
        out_stall <= out_stall - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on input items, check output items in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        expected_display_q.push_back(entry_step(entry_st, in_if.payload, commit_limit));
        n_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_display_q.size() == 0)
          report_mismatch("result with nothing expected", 32'(out_if.payload), 0);
        else
          compare_display(out_if.payload, expected_display_q.pop_front());
        n_checked++;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // apb transfer: setup, access, done when pready is seen
  task automatic reg_access(input bit wr, input logic [mtkte_pkg::ApbDataW-1:0] wdata,
                            output logic [mtkte_pkg::ApbDataW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TimeoutAddr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_timeout_reg(input logic [mtkte_pkg::TickW-1:0] want);
    logic [mtkte_pkg::ApbDataW-1:0] rd;
    reg_access(1'b0, '0, rd);
    if (rd !== mtkte_pkg::ApbDataW'(want))
      report_mismatch("timeout register read", rd, 32'(want));
  endtask

  task automatic set_timeout(input logic [mtkte_pkg::TickW-1:0] v);
    logic [mtkte_pkg::ApbDataW-1:0] rd;
    reg_access(1'b1, mtkte_pkg::ApbDataW'(v), rd);
    commit_limit = v;
    check_timeout_reg(v);
    plan_st = entry_st;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (n_accepted != n_queued || expected_display_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // queue an item, tracking where the block will be
  task automatic queue_item(input mtkte_pkg::mode_e m,
                            input logic [mtkte_pkg::KeyW-1:0] k);
    mtkte_pkg::in_item_t  it;
    mtkte_pkg::out_item_t unused;
    it.mode = m;
    it.key  = k;
    unused  = entry_step(plan_st, it, commit_limit);
    key_event_q.push_back(it);
    n_queued++;
  endtask

  task automatic queue_key(input logic [mtkte_pkg::KeyW-1:0] k);
    queue_item(mtkte_pkg::MODE_KEY, k);
  endtask

  task automatic queue_tick();
    queue_item(mtkte_pkg::MODE_TICK, 2'($urandom_range(0, 3)));
  endtask

  // one character entry with random content, or a little noise
  task automatic queue_episode();
    logic [mtkte_pkg::KeyW-1:0] k;
    logic [mtkte_pkg::KeyW-1:0] other;
    int unsigned                taps;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 4))
        queue_item(mtkte_pkg::mode_e'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    end else begin
      while (plan_st.pend) queue_tick();
      if (!plan_st.sel) queue_key(2'($urandom_range(0, 3)));
      k = 2'($urandom_range(0, 2));
      queue_key(k);
      taps = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 19) : $urandom_range(0, 7);
      repeat (taps) begin
        // ignored keys and ticks short of the timeout in between
        if ($urandom_range(0, 5) == 0) begin
          other = 2'(k + $urandom_range(1, 3));
          queue_key(other);
        end
        if ($urandom_range(0, 3) == 0 && int'(plan_st.idle) + 1 < int'(commit_limit))
          queue_tick();
        queue_key(k);
      end
      while (plan_st.pend) queue_tick();
      if ($urandom_range(0, 2) == 0) queue_key(mtkte_pkg::ReturnKey);
    end
  endtask

  task automatic run_random(input logic [mtkte_pkg::TickW-1:0] limit,
                            input int unsigned n_items);
    int unsigned start;
    set_timeout(limit);
    start = n_queued;
    while (n_queued - start < n_items) queue_episode();
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    check_timeout_reg(mtkte_pkg::TimeoutRst);

    // directed: phases, wrap-around, ignored keys and ticks, commits
    set_timeout(8'd2);
    queue_tick();                          // tick in row select
    queue_key(2'd0);                       // row 0
    queue_tick();                          // tick with nothing pending
    queue_key(2'd1);                       // 'a' pending
    queue_key(2'd2);                       // other key ignored
    queue_key(mtkte_pkg::ReturnKey);       // return key ignored while pending
    repeat (7) queue_key(2'd1);            // through the table and back to 'a'
    queue_tick();
    queue_tick();                          // commit
    queue_key(mtkte_pkg::ReturnKey);       // back to row select
    queue_key(2'd3);                       // row 3
    queue_key(2'd0);
    queue_key(2'd0);                       // single-character wrap
    queue_tick();
    queue_tick();
    queue_key(mtkte_pkg::ReturnKey);
    queue_key(2'd2);                       // row 2
    queue_key(2'd2);
    queue_tick();
    queue_key(2'd2);                       // tap clears the idle count
    queue_tick();
    queue_tick();
    wait_drained();

    run_random(8'd1, 300);
    run_random(8'd0, 150);
    run_random(8'($urandom_range(3, 9)), 300);
    run_random(8'd255, 550);

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
